// ===== rtl/core/circle_collision_test_assert.svh =====
// Assertion macros for the circle collision test block.
// Used by the port checker; depends on nothing else.
`ifndef CIRCLE_COLLISION_TEST_ASSERT_SVH
`define CIRCLE_COLLISION_TEST_ASSERT_SVH

// same-cycle implication
`define CCT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("collision check failed");

// implication after a fixed number of cycles
`define CCT_ASSERT_DLY(lbl, clk, rstn, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##n (cons)) \
    else $error("collision check latency failed");

`endif

// ===== rtl/core/cct_pkg.sv =====
// Shared types, widths and helpers for the circle collision test block.
// No dependencies.
package cct_pkg;

  localparam int PosW     = 24;
  localparam int SizeW    = 20;
  localparam int ScaleW   = 16;
  localparam int ScW      = 24;
  localparam int OffW     = 26;
  localparam int ReachW   = 25;
  localparam int SqW      = 50;
  localparam int Dist2W   = 51;
  localparam int RootW    = 26;
  localparam int SqRemW   = 30;
  localparam int NormW    = 16;
  localparam int QW       = 17;
  localparam int DivRemW  = 42;
  localparam int FracSh   = 15;
  localparam int FifoDepth = 8;
  localparam int FifoAw   = 3;
  localparam int FifoCntW = 4;
  localparam int InflW    = 2;
  localparam int Latency  = 47;

  localparam logic ActBox    = 1'b0;
  localparam logic ActCircle = 1'b1;

  localparam logic [ScW-1:0] ScMax = {ScW{1'b1}};

  typedef struct packed {
    logic                     hit;
    logic                     zero;
    logic signed [OffW-1:0]   dx;
    logic signed [OffW-1:0]   dy;
    logic [ReachW-1:0]        reach;
    logic [Dist2W-1:0]        dist2;
  } item_t;

  typedef struct packed {
    logic                     hit;
    logic                     zero;
    logic signed [OffW-1:0]   dx;
    logic signed [OffW-1:0]   dy;
    logic [ReachW-1:0]        reach;
    logic [Dist2W-1:0]        dist2;
    logic [SqRemW-1:0]        rem;
    logic [RootW-1:0]         root;
  } sq_t;

  typedef struct packed {
    logic                     hit;
    logic                     zero;
    logic                     negx;
    logic                     negy;
    logic [ScW-1:0]           depth;
    logic [RootW-1:0]         dlen;
    logic [DivRemW-1:0]       remx;
    logic [DivRemW-1:0]       remy;
    logic [QW-1:0]            qx;
    logic [QW-1:0]            qy;
  } dv_t;

  function automatic logic [ScW-1:0] scale_size(input logic [SizeW-1:0] size,
                                                input logic [ScaleW-1:0] scale);
    logic [SizeW+ScaleW-1:0] p;
    logic [SizeW+ScaleW-9:0] s;
    p = size * scale;
    s = p[SizeW+ScaleW-1:8];
    if (s > (SizeW+ScaleW-8)'(ScMax)) return ScMax;
    return s[ScW-1:0];
  endfunction

  function automatic logic signed [NormW-1:0] sat_norm(input logic neg,
                                                       input logic [QW-1:0] q);
    if (neg) return q[QW-1] ? NormW'(-32768) : NormW'(-$signed({1'b0, q[NormW-1:0]}));
    return (q[QW-1] || q[NormW-1]) ? NormW'(32767) : $signed(q[NormW-1:0]);
  endfunction

endpackage

// ===== rtl/core/cct_front.sv =====
// Front end: scales sizes, forms offsets, squares and classifies hit.
// Depends on cct_pkg.
module cct_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic                               action_i,
  input  logic signed [cct_pkg::PosW-1:0]    circle_x_i,
  input  logic signed [cct_pkg::PosW-1:0]    circle_y_i,
  input  logic [cct_pkg::SizeW-1:0]          circle_radius_i,
  input  logic [cct_pkg::ScaleW-1:0]         circle_scale_x_i,
  input  logic [cct_pkg::ScaleW-1:0]         circle_scale_y_i,
  input  logic signed [cct_pkg::PosW-1:0]    other_x_i,
  input  logic signed [cct_pkg::PosW-1:0]    other_y_i,
  input  logic [cct_pkg::SizeW-1:0]          other_size_x_i,
  input  logic [cct_pkg::SizeW-1:0]          other_size_y_i,
  input  logic [cct_pkg::ScaleW-1:0]         other_scale_x_i,
  input  logic [cct_pkg::ScaleW-1:0]         other_scale_y_i,
  output logic                               push_o,
  output cct_pkg::item_t                     item_o,
  output logic [cct_pkg::InflW-1:0]          inflight_o
);

  logic v1_q, v2_q, v3_q;
  logic act1_q;
  logic signed [cct_pkg::PosW-1:0] cx1_q, cy1_q, ox1_q, oy1_q;
  logic [cct_pkg::ScW-1:0] rad1_q, ex1_q, ey1_q;
  logic [cct_pkg::ScaleW-1:0] cs_max, os_max, sx_sel;

  logic signed [cct_pkg::OffW-1:0] dx2_d, dy2_d, dx2_q, dy2_q;
  logic signed [cct_pkg::OffW-1:0] lox, hix, loy, hiy, cxw, cyw, oxw, oyw;
  logic [cct_pkg::ReachW-1:0] reach2_d, reach2_q;

  logic signed [cct_pkg::OffW-1:0] dx3_q, dy3_q;
  logic [cct_pkg::ReachW-1:0] reach3_q;
  logic signed [2*cct_pkg::OffW-1:0] px, py;
  logic [2*cct_pkg::ReachW-1:0] pr;
  logic [cct_pkg::SqW-1:0] sqx_q, sqy_q, rr_q;
  logic [cct_pkg::Dist2W-1:0] dist2;

  always_comb begin
    cs_max = (circle_scale_x_i > circle_scale_y_i) ? circle_scale_x_i : circle_scale_y_i;
    os_max = (other_scale_x_i > other_scale_y_i) ? other_scale_x_i : other_scale_y_i;
    sx_sel = (action_i == cct_pkg::ActCircle) ? os_max : other_scale_x_i;
  end

  always_ff @(posedge clk_i) begin
    act1_q <= action_i;
    cx1_q  <= circle_x_i;
    cy1_q  <= circle_y_i;
    ox1_q  <= other_x_i;
    oy1_q  <= other_y_i;
    rad1_q <= cct_pkg::scale_size(circle_radius_i, cs_max);
    ex1_q  <= cct_pkg::scale_size(other_size_x_i, sx_sel);
    ey1_q  <= cct_pkg::scale_size(other_size_y_i, other_scale_y_i);
  end

  always_comb begin
    cxw = cct_pkg::OffW'(cx1_q);
    cyw = cct_pkg::OffW'(cy1_q);
    oxw = cct_pkg::OffW'(ox1_q);
    oyw = cct_pkg::OffW'(oy1_q);
    lox = oxw - $signed({2'b00, ex1_q});
    hix = oxw + $signed({2'b00, ex1_q});
    loy = oyw - $signed({2'b00, ey1_q});
    hiy = oyw + $signed({2'b00, ey1_q});
    if (act1_q == cct_pkg::ActCircle) begin
      dx2_d    = oxw - cxw;
      dy2_d    = oyw - cyw;
      reach2_d = {1'b0, rad1_q} + {1'b0, ex1_q};
    end else begin
      priority if (cxw < lox) dx2_d = cxw - lox;
      else if (cxw > hix)     dx2_d = cxw - hix;
      else                    dx2_d = '0;
      priority if (cyw < loy) dy2_d = cyw - loy;
      else if (cyw > hiy)     dy2_d = cyw - hiy;
      else                    dy2_d = '0;
      reach2_d = {1'b0, rad1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    dx2_q    <= dx2_d;
    dy2_q    <= dy2_d;
    reach2_q <= reach2_d;
  end

  always_comb begin
    px = dx2_q * dx2_q;
    py = dy2_q * dy2_q;
    pr = reach2_q * reach2_q;
  end

  always_ff @(posedge clk_i) begin
    dx3_q    <= dx2_q;
    dy3_q    <= dy2_q;
    reach3_q <= reach2_q;
    sqx_q    <= px[cct_pkg::SqW-1:0];
    sqy_q    <= py[cct_pkg::SqW-1:0];
    rr_q     <= pr[cct_pkg::SqW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_comb begin
    dist2        = {1'b0, sqx_q} + {1'b0, sqy_q};
    item_o.hit   = dist2 <= {1'b0, rr_q};
    item_o.zero  = dist2 == '0;
    item_o.dx    = dx3_q;
    item_o.dy    = dy3_q;
    item_o.reach = reach3_q;
    item_o.dist2 = dist2;
    push_o       = v3_q;
    inflight_o   = cct_pkg::InflW'({1'b0, v1_q} + {1'b0, v2_q} + {1'b0, v3_q});
  end

endmodule

// ===== rtl/core/cct_fifo.sv =====
// Short queue between the front end and the back end.
// Depends on cct_pkg.
module cct_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  cct_pkg::item_t                item_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output cct_pkg::item_t                item_o,
  output logic [cct_pkg::FifoCntW-1:0]  cnt_o
);

  cct_pkg::item_t mem_q [cct_pkg::FifoDepth];
  logic [cct_pkg::FifoAw-1:0] wp_q, rp_q;
  logic [cct_pkg::FifoCntW-1:0] cnt_q;
  logic do_pop;

  assign valid_o = cnt_q != '0;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem_q[rp_q];
  assign cnt_o   = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (do_pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + cct_pkg::FifoCntW'(push_i) - cct_pkg::FifoCntW'(do_pop);
    end
  end

endmodule

// ===== rtl/core/cct_back.sv =====
// Back end: pipelined square root, pipelined normal division, result register.
// Depends on cct_pkg.
module cct_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  cct_pkg::item_t                    item_i,
  output logic                              valid_o,
  output logic                              hit_o,
  output logic                              normal_valid_o,
  output logic signed [cct_pkg::NormW-1:0]  normal_x_o,
  output logic signed [cct_pkg::NormW-1:0]  normal_y_o,
  output logic [cct_pkg::ScW-1:0]           depth_o
);

  localparam int DivN = cct_pkg::QW;
  localparam int SqN  = cct_pkg::RootW;

  logic           sv_q [SqN];
  cct_pkg::sq_t   sq_q [SqN];
  logic           dvv_q [DivN];
  cct_pkg::dv_t   dv_q [DivN];

  for (genvar k = 0; k < SqN; k++) begin : g_sq
    localparam int Pos = 2 * (SqN - 1 - k);
    cct_pkg::sq_t src, nxt;
    logic src_v;
    logic [2*SqN-1:0] vw;
    logic [1:0] pair;
    logic [cct_pkg::SqRemW-1:0] rem_sh, trial;

    if (k == 0) begin : g_first
      always_comb begin
        src       = '0;
        src.hit   = item_i.hit;
        src.zero  = item_i.zero;
        src.dx    = item_i.dx;
        src.dy    = item_i.dy;
        src.reach = item_i.reach;
        src.dist2 = item_i.dist2;
        src_v     = in_valid_i;
      end
    end else begin : g_next
      assign src   = sq_q[k-1];
      assign src_v = sv_q[k-1];
    end

    always_comb begin
      vw     = {1'b0, src.dist2};
      pair   = vw[Pos+1 -: 2];
      rem_sh = {src.rem[cct_pkg::SqRemW-3:0], pair};
      trial  = {2'b00, src.root, 2'b01};
      nxt    = src;
      if (rem_sh >= trial) begin
        nxt.rem  = rem_sh - trial;
        nxt.root = {src.root[SqN-2:0], 1'b1};
      end else begin
        nxt.rem  = rem_sh;
        nxt.root = {src.root[SqN-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      sq_q[k] <= nxt;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k] <= 1'b0;
      else         sv_q[k] <= src_v;
    end
  end

  for (genvar i = 0; i < DivN; i++) begin : g_dv
    localparam int Bit = DivN - 1 - i;
    cct_pkg::dv_t src, nxt;
    logic src_v;
    logic [cct_pkg::DivRemW-1:0] dsh;

    if (i == 0) begin : g_first
      cct_pkg::sq_t s;
      logic [cct_pkg::ReachW-1:0] dep;
      logic [cct_pkg::OffW-1:0] ax, ay;
      assign s = sq_q[SqN-1];
      always_comb begin
        dep      = s.reach - s.root[cct_pkg::ReachW-1:0];
        ax       = s.dx[cct_pkg::OffW-1] ? cct_pkg::OffW'(-s.dx) : cct_pkg::OffW'(s.dx);
        ay       = s.dy[cct_pkg::OffW-1] ? cct_pkg::OffW'(-s.dy) : cct_pkg::OffW'(s.dy);
        src      = '0;
        src.hit  = s.hit;
        src.zero = s.zero;
        src.negx = s.dx[cct_pkg::OffW-1];
        src.negy = s.dy[cct_pkg::OffW-1];
        src.depth = dep[cct_pkg::ReachW-1] ? cct_pkg::ScMax : dep[cct_pkg::ScW-1:0];
        src.dlen = s.root;
        src.remx = cct_pkg::DivRemW'({ax, {cct_pkg::FracSh{1'b0}}});
        src.remy = cct_pkg::DivRemW'({ay, {cct_pkg::FracSh{1'b0}}});
        src_v    = sv_q[SqN-1];
      end
    end else begin : g_next
      assign src   = dv_q[i-1];
      assign src_v = dvv_q[i-1];
    end

    always_comb begin
      dsh = cct_pkg::DivRemW'(src.dlen) << Bit;
      nxt = src;
      if (src.remx >= dsh) begin
        nxt.remx    = src.remx - dsh;
        nxt.qx[Bit] = 1'b1;
      end
      if (src.remy >= dsh) begin
        nxt.remy    = src.remy - dsh;
        nxt.qy[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[i] <= nxt;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dvv_q[i] <= 1'b0;
      else         dvv_q[i] <= src_v;
    end
  end

  cct_pkg::dv_t f;
  logic nv;
  assign f  = dv_q[DivN-1];
  assign nv = f.hit && !f.zero;

  always_ff @(posedge clk_i) begin
    hit_o          <= f.hit;
    normal_valid_o <= nv;
    normal_x_o     <= nv ? cct_pkg::sat_norm(f.negx, f.qx) : '0;
    normal_y_o     <= nv ? cct_pkg::sat_norm(f.negy, f.qy) : '0;
    depth_o        <= f.hit ? f.depth : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else         valid_o <= dvv_q[DivN-1];
  end

endmodule

// ===== rtl/core/circle_collision_test.sv =====
// Circle collision test: an accepted pair runs through front end, queue and back end
// to valid_o, one item per cycle sustained; the front end, queue and back end are fully
// pipelined (26-stage square root, 17-stage divider), and the back end drains
// the queue every cycle, so busy never rises. Results cannot be stalled.
// Asynchronous active-low reset clears all valid bits and queue pointers.
module circle_collision_test (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               action_i,
  input  logic signed [cct_pkg::PosW-1:0]    circle_x_i,
  input  logic signed [cct_pkg::PosW-1:0]    circle_y_i,
  input  logic [cct_pkg::SizeW-1:0]          circle_radius_i,
  input  logic [cct_pkg::ScaleW-1:0]         circle_scale_x_i,
  input  logic [cct_pkg::ScaleW-1:0]         circle_scale_y_i,
  input  logic signed [cct_pkg::PosW-1:0]    other_x_i,
  input  logic signed [cct_pkg::PosW-1:0]    other_y_i,
  input  logic [cct_pkg::SizeW-1:0]          other_size_x_i,
  input  logic [cct_pkg::SizeW-1:0]          other_size_y_i,
  input  logic [cct_pkg::ScaleW-1:0]         other_scale_x_i,
  input  logic [cct_pkg::ScaleW-1:0]         other_scale_y_i,
  output logic                               valid_o,
  output logic                               hit_o,
  output logic                               normal_valid_o,
  output logic signed [cct_pkg::NormW-1:0]   normal_x_o,
  output logic signed [cct_pkg::NormW-1:0]   normal_y_o,
  output logic [cct_pkg::ScW-1:0]            depth_o
);

  logic accept, push, q_valid;
  cct_pkg::item_t f_item, q_item;
  logic [cct_pkg::InflW-1:0] inflight;
  logic [cct_pkg::FifoCntW-1:0] cnt;

  assign accept = start && !busy;
  assign busy   = (5'(cnt) + 5'(inflight)) >= 5'(cct_pkg::FifoDepth);

  cct_front u_front (
    .clk_i, .rst_ni,
    .accept_i (accept),
    .action_i, .circle_x_i, .circle_y_i, .circle_radius_i,
    .circle_scale_x_i, .circle_scale_y_i, .other_x_i, .other_y_i,
    .other_size_x_i, .other_size_y_i, .other_scale_x_i, .other_scale_y_i,
    .push_o     (push),
    .item_o     (f_item),
    .inflight_o (inflight)
  );

  cct_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i  (f_item),
    .pop_i   (q_valid),
    .valid_o (q_valid),
    .item_o  (q_item),
    .cnt_o   (cnt)
  );

  cct_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i (q_valid),
    .item_i     (q_item),
    .valid_o, .hit_o, .normal_valid_o, .normal_x_o, .normal_y_o, .depth_o
  );

endmodule

// ===== rtl/core/cct_checker.sv =====
// Port-level checker for circle_collision_test, bound to the top level.
// Depends on cct_pkg and circle_collision_test_assert.svh.
`include "circle_collision_test_assert.svh"
module cct_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               valid_o,
  input logic                               hit_o,
  input logic                               normal_valid_o,
  input logic signed [cct_pkg::NormW-1:0]   normal_x_o,
  input logic signed [cct_pkg::NormW-1:0]   normal_y_o,
  input logic [cct_pkg::ScW-1:0]            depth_o
);

  `CCT_ASSERT_IMP(a_miss_clean, clk_i, rst_ni, valid_o && !hit_o, !normal_valid_o && depth_o == '0)
  `CCT_ASSERT_IMP(a_nv_hit, clk_i, rst_ni, valid_o && normal_valid_o, hit_o)
  `CCT_ASSERT_IMP(a_norm_zero, clk_i, rst_ni, valid_o && !normal_valid_o, normal_x_o == '0 && normal_y_o == '0)
  `CCT_ASSERT_DLY(a_latency, clk_i, rst_ni, start && !busy, 48, valid_o)

endmodule

bind circle_collision_test cct_checker u_cct_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for circle_collision_test: box and circle tests, random pairs.
// Depends on cct_pkg and the circle_collision_test RTL.
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    logic                     action;
    logic signed [23:0]       cx, cy;
    logic [19:0]              crad;
    logic [15:0]              csx, csy;
    logic signed [23:0]       ox, oy;
    logic [19:0]              osx_sz, osy_sz;
    logic [15:0]              osx, osy;
  } pair_t;

  typedef struct {
    logic                     hit;
    logic                     nvalid;
    logic signed [15:0]       nx, ny;
    logic [23:0]              depth;
  } contact_t;

  function automatic longint unsigned scaled(logic [19:0] sz, logic [15:0] sc);
    longint unsigned p;
    p = (longint'(sz) * longint'(sc)) >> 8;
    return (p > 64'hFFFFFF) ? 64'hFFFFFF : p;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] unit_comp(longint d, longint unsigned dlen);
    longint n;
    n = (d * 32768) / longint'(dlen);
    if (n < -32768) n = -32768;
    if (n > 32767) n = 32767;
    return n[15:0];
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t r;
    longint dx, dy, ex, ey, cx, cy, ox, oy;
    longint unsigned rad, reach, d2, dlen, dep;
    r = '{default: '0};
    cx = p.cx; cy = p.cy; ox = p.ox; oy = p.oy;
    rad = scaled(p.crad, (p.csx > p.csy) ? p.csx : p.csy);
    if (p.action == cct_pkg::ActBox) begin
      ex = scaled(p.osx_sz, p.osx);
      ey = scaled(p.osy_sz, p.osy);
      dx = cx - clampl(cx, ox - ex, ox + ex);
      dy = cy - clampl(cy, oy - ey, oy + ey);
      reach = rad;
    end else begin
      dx = ox - cx;
      dy = oy - cy;
      reach = rad + scaled(p.osx_sz, (p.osx > p.osy) ? p.osx : p.osy);
    end
    d2 = longint'(dx * dx) + longint'(dy * dy);
    if (d2 > reach * reach) return r;
    dlen = root_floor(d2);
    dep = reach - dlen;
    r.hit = 1'b1;
    r.depth = (dep > 64'hFFFFFF) ? 24'hFFFFFF : dep[23:0];
    if (d2 != 0) begin
      r.nvalid = 1'b1;
      r.nx = unit_comp(dx, dlen);
      r.ny = unit_comp(dy, dlen);
    end
    return r;
  endfunction

  class contact_board;
    contact_t pending[$];
    int errors;

    function void note_pair(pair_t p);
      pending.push_back(predict_contact(p));
    endfunction

    function void check_contact(contact_t got);
      contact_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.hit !== e.hit) begin
        $error("hit exp %0d got %0d", e.hit, got.hit); errors++;
      end
      if (got.nvalid !== e.nvalid) begin
        $error("normal_valid exp %0d got %0d", e.nvalid, got.nvalid); errors++;
      end
      if (got.nx !== e.nx) begin
        $error("normal_x exp %0d got %0d", e.nx, got.nx); errors++;
      end
      if (got.ny !== e.ny) begin
        $error("normal_y exp %0d got %0d", e.ny, got.ny); errors++;
      end
      if (got.depth !== e.depth) begin
        $error("depth exp %0d got %0d", e.depth, got.depth); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  pair_t drv = '{default: '0};
  logic valid_o, hit_o, normal_valid_o;
  logic signed [15:0] normal_x_o, normal_y_o;
  logic [23:0] depth_o;
  contact_board board = new();
  int cycles = 0;

  circle_collision_test DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .action_i(drv.action), .circle_x_i(drv.cx), .circle_y_i(drv.cy),
    .circle_radius_i(drv.crad), .circle_scale_x_i(drv.csx), .circle_scale_y_i(drv.csy),
    .other_x_i(drv.ox), .other_y_i(drv.oy), .other_size_x_i(drv.osx_sz),
    .other_size_y_i(drv.osy_sz), .other_scale_x_i(drv.osx), .other_scale_y_i(drv.osy),
    .valid_o(valid_o), .hit_o(hit_o), .normal_valid_o(normal_valid_o),
    .normal_x_o(normal_x_o), .normal_y_o(normal_y_o), .depth_o(depth_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("circle_collision_test verification failed");
      $finish;
    end
    if (rst_ni && valid_o)
      board.check_contact('{hit: hit_o, nvalid: normal_valid_o, nx: normal_x_o,
                            ny: normal_y_o, depth: depth_o});
  end

  task automatic send_pair(pair_t p);
    @(negedge clk_i);
    drv <= p;
    start <= 1'b1;
    forever begin
      #1;
      if (!busy) break;
      @(negedge clk_i);
    end
    board.note_pair(p);
    @(posedge clk_i);
  endtask

  task automatic idle_burst();
    @(negedge clk_i);
    start <= 1'b0;
    drv <= '{default: '0, cx: $urandom, ox: $urandom};
    repeat ($urandom_range(0, 11)) @(negedge clk_i);
  endtask

  function automatic pair_t noise_pair();
    pair_t p;
    p.action = $urandom; p.cx = $urandom; p.cy = $urandom;
    p.crad = $urandom; p.csx = $urandom; p.csy = $urandom;
    p.ox = $urandom; p.oy = $urandom; p.osx_sz = $urandom; p.osy_sz = $urandom;
    p.osx = $urandom; p.osy = $urandom;
    return p;
  endfunction

  // nearby shapes of modest size so hits and misses both occur
  function automatic pair_t near_pair();
    pair_t p;
    int sh;
    p = noise_pair();
    sh = $urandom_range(4, 19);
    p.crad = $urandom_range(0, (1 << sh) - 1);
    p.osx_sz = $urandom_range(0, (1 << sh) - 1);
    p.osy_sz = $urandom_range(0, (1 << sh) - 1);
    p.csx = $urandom_range(64, 768); p.csy = $urandom_range(64, 768);
    p.osx = $urandom_range(64, 768); p.osy = $urandom_range(64, 768);
    p.ox = p.cx + $signed(24'($urandom_range(0, 1 << (sh + 1)))) - (1 << sh);
    p.oy = p.cy + $signed(24'($urandom_range(0, 1 << (sh + 1)))) - (1 << sh);
    if ($urandom_range(0, 9) == 0) begin
      p.ox = p.cx; p.oy = p.cy;
    end
    return p;
  endfunction

  initial begin
    pair_t p;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int a = 0; a < 2; a++) begin
      p = '{default: '0};
      p.action = a;
      send_pair(p);
      p = '{action: a, cx: 24'h7FFFFF, cy: 24'h800000, crad: 20'hFFFFF,
            csx: 16'hFFFF, csy: 16'hFFFF, ox: 24'h800000, oy: 24'h7FFFFF,
            osx_sz: 20'hFFFFF, osy_sz: 20'hFFFFF, osx: 16'hFFFF, osy: 16'hFFFF};
      send_pair(p);
      p = '{action: a, cx: 24'h7FFFFF, cy: 24'h7FFFFF, crad: 20'h100,
            csx: 16'h100, csy: 16'h80, ox: 24'h800000, oy: 24'h800000,
            osx_sz: 20'h100, osy_sz: 20'h100, osx: 16'h100, osy: 16'h100};
      send_pair(p);
      p = '{action: a, cx: 0, cy: 0, crad: 20'h1000, csx: 16'h100, csy: 16'h200,
            ox: 24'h1800, oy: 0, osx_sz: 20'h800, osy_sz: 20'h800,
            osx: 16'h100, osy: 16'h100};
      send_pair(p);
      p.oy = -24'sh1800;
      send_pair(p);
      p = '{action: a, cx: 5, cy: -7, crad: 20'h40, csx: 0, csy: 16'h100,
            ox: 5, oy: -7, osx_sz: 20'h40, osy_sz: 0, osx: 0, osy: 16'h100};
      send_pair(p);
      p.crad = 0;
      send_pair(p);
      p = '{action: a, cx: 24'h300, cy: 0, crad: 20'h100, csx: 16'h100, csy: 16'h100,
            ox: 0, oy: 0, osx_sz: 20'h200, osy_sz: 20'h200, osx: 16'h100, osy: 16'h100};
      send_pair(p);
      p.cx = 24'h301;
      send_pair(p);
    end

    for (int i = 0; i < 1350; i++) begin
      if (i == 600) begin
        @(negedge clk_i);
        start <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk_i);
      end
      if (i < 1150 && $urandom_range(0, 3) == 0) idle_burst();
      send_pair(($urandom_range(0, 4) == 0) ? noise_pair() : near_pair());
    end
    @(negedge clk_i);
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (cct_pkg::Latency + 10) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("circle_collision_test verification clean");
    end else begin
      $display("circle_collision_test verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cct_pkg.sv
rtl/core/cct_front.sv
rtl/core/cct_fifo.sv
rtl/core/cct_back.sv
rtl/core/circle_collision_test.sv
rtl/core/cct_checker.sv
tb/sv/tb_top.sv
